// ===== hdl/l2fr_pkg.sv =====
`default_nettype none

package l2fr_pkg;

	localparam int BUF_BYTES_DEF = 256;

	localparam logic [1:0] LID_CONT  = 2'd1;
	localparam logic [1:0] LID_START = 2'd2;
	localparam int HDR_LEN = 4;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_COMPLETE  = 3'd1,
		EV_SHORT     = 3'd2,
		EV_TOO_LARGE = 3'd3,
		EV_ORPHAN    = 3'd4,
		EV_BAD_LLID  = 3'd5
	} l2fr_event_t;

	typedef struct packed {
		logic [1:0] link_id;
		logic       frag_first;
		logic       frag_last;
		logic       byte_present;
		logic [7:0] data_byte;
	} l2fr_frag_t;

	typedef struct packed {
		logic        store_valid;
		logic [7:0]  store_index;
		logic [7:0]  store_byte;
		logic [2:0]  event_res;
		logic [15:0] frame_length;
		logic [15:0] channel_id;
	} l2fr_result_t;

endpackage

`default_nettype wire

// ===== hdl/l2fr_stream_if.sv =====
`default_nettype none

interface l2fr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/l2fr_core.sv =====
`default_nettype none

module l2fr_core
	import l2fr_pkg::*;
#(
	parameter int BUF_BYTES = BUF_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire l2fr_frag_t   item,
	output l2fr_result_t      result
);

	localparam int CNT_W = ($clog2(BUF_BYTES + 1) > 8) ? $clog2(BUF_BYTES + 1) : 8;
	localparam logic [CNT_W-1:0] BUF_LIM = CNT_W'(BUF_BYTES);
	localparam logic [16:0] BUF_LIM17 = 17'(BUF_BYTES);

	logic             in_progress_q;
	logic [CNT_W-1:0] expected_total_q;
	logic [CNT_W-1:0] received_count_q;
	logic [7:0]       frag_position_q;
	logic [1:0]       frag_kind_q;
	logic             frag_dropped_q;
	logic [23:0]      header_bytes_q;

	logic             in_progress_d;
	logic [CNT_W-1:0] expected_total_d;
	logic [CNT_W-1:0] received_count_d;
	logic [7:0]       frag_position_d;
	logic [1:0]       frag_kind_d;
	logic             frag_dropped_d;
	logic [23:0]      header_bytes_d;

	logic [1:0]       kind;
	logic [7:0]       pos;
	logic [16:0]      total;

	always_comb begin
		in_progress_d    = in_progress_q;
		expected_total_d = expected_total_q;
		received_count_d = received_count_q;
		frag_position_d  = frag_position_q;
		frag_kind_d      = frag_kind_q;
		frag_dropped_d   = frag_dropped_q;
		header_bytes_d   = header_bytes_q;
		result           = '0;
		total            = '0;

		if (item.frag_first) begin
			frag_kind_d     = item.link_id;
			frag_position_d = '0;
			frag_dropped_d  = 1'b0;
			if (item.link_id == LID_START) begin
				in_progress_d    = 1'b0;
				expected_total_d = '0;
				received_count_d = '0;
				header_bytes_d   = '0;
			end
		end
		kind = frag_kind_d;
		pos  = frag_position_d;

		if (kind == LID_START) begin
			if (item.byte_present) begin
				if (!frag_dropped_d) begin
					case (pos)
						8'd0: header_bytes_d = {16'h0, item.data_byte};
						8'd1: begin
							total = 17'({item.data_byte, header_bytes_d[7:0]}) + 17'(HDR_LEN);
							if (total > BUF_LIM17) begin
								frag_dropped_d = 1'b1;
							end else begin
								expected_total_d = total[CNT_W-1:0];
								header_bytes_d[15:8] = item.data_byte;
							end
						end
						8'd2: header_bytes_d[23:16] = item.data_byte;
						8'd3: header_bytes_d = {8'h0, item.data_byte, header_bytes_d[23:16]};
						default: ;
					endcase
					if (!frag_dropped_d && CNT_W'(pos) < BUF_LIM) begin
						result.store_valid = 1'b1;
						result.store_index = pos;
						result.store_byte  = item.data_byte;
					end
				end
				if (frag_position_d != 8'hFF) begin
					frag_position_d = frag_position_d + 8'd1;
				end
				received_count_d = CNT_W'(frag_position_d);
			end
			if (item.frag_last) begin
				if (frag_position_d < 8'(HDR_LEN)) begin
					result.event_res = EV_SHORT;
				end else if (frag_dropped_d) begin
					result.event_res = EV_TOO_LARGE;
				end else if (CNT_W'(frag_position_d) >= expected_total_d) begin
					result.event_res    = EV_COMPLETE;
					result.frame_length = 16'(17'(expected_total_d) - 17'(HDR_LEN));
					result.channel_id   = header_bytes_d[15:0];
				end else begin
					in_progress_d = 1'b1;
				end
			end
		end else if (kind == LID_CONT) begin
			if (in_progress_d && item.byte_present && received_count_d < expected_total_d) begin
				result.store_valid = 1'b1;
				result.store_index = received_count_d[7:0];
				result.store_byte  = item.data_byte;
				received_count_d   = received_count_d + CNT_W'(1);
			end
			if (item.frag_last) begin
				if (!in_progress_d) begin
					result.event_res = EV_ORPHAN;
				end else if (received_count_d >= expected_total_d) begin
					result.event_res    = EV_COMPLETE;
					result.frame_length = 16'(17'(expected_total_d) - 17'(HDR_LEN));
					result.channel_id   = header_bytes_d[15:0];
					in_progress_d       = 1'b0;
				end
			end
		end else begin
			if (item.frag_last) begin
				result.event_res = EV_BAD_LLID;
			end
		end

		if (item.frag_last) begin
			frag_kind_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_progress_q    <= 1'b0;
			expected_total_q <= '0;
			received_count_q <= '0;
			frag_position_q  <= '0;
			frag_kind_q      <= '0;
			frag_dropped_q   <= 1'b0;
			header_bytes_q   <= '0;
		end else if (step) begin
			in_progress_q    <= in_progress_d;
			expected_total_q <= expected_total_d;
			received_count_q <= received_count_d;
			frag_position_q  <= frag_position_d;
			frag_kind_q      <= frag_kind_d;
			frag_dropped_q   <= frag_dropped_d;
			header_bytes_q   <= header_bytes_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/l2cap_fragment_reassembler_unit.sv =====
// Channel  Dir  Payload        Handshake
// frag     in   l2fr_frag_t    valid/ready, item taken when both high
// res      out  l2fr_result_t  valid/ready, item taken when both high
//
// One item per cycle sustained while res is ready; each result passes through s1 and then the s2 register to res.
// Stage s1 holds the input item, frame state and stage s2 update as it moves on.
// A stall on res holds both stages; frag.ready stays high while s1 is empty or moving.
// arst_n clears the valid flags and the frame state at once; payload is not reset.
`default_nettype none

module l2cap_fragment_reassembler_unit
	import l2fr_pkg::*;
#(
	parameter int BUF_BYTES = BUF_BYTES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	l2fr_stream_if.sink    frag,
	l2fr_stream_if.source  res
);

	l2fr_frag_t   item_s1;
	logic         valid_s1;
	l2fr_result_t result_s2;
	logic         valid_s2;
	l2fr_result_t result_next;
	logic         advance;

	assign advance    = !valid_s2 || res.ready;
	assign frag.ready = !valid_s1 || advance;
	assign res.valid  = valid_s2;
	assign res.data   = result_s2;

	l2fr_core #(
		.BUF_BYTES(BUF_BYTES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (valid_s1 && advance),
		.item  (item_s1),
		.result(result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (frag.ready) begin
				valid_s1 <= frag.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frag.ready && frag.valid) begin
			item_s1 <= frag.data;
		end
		if (advance && valid_s1) begin
			result_s2 <= result_next;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/l2fr_checker.sv =====
`default_nettype none

module l2fr_checker
	import l2fr_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         res_valid,
	input wire logic         res_ready,
	input wire l2fr_result_t res_data
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result item changed");

	a_store_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.store_valid |->
			res_data.store_index == 8'h00 && res_data.store_byte == 8'h00)
		else $error("store fields set without a write");

	a_info_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.event_res != EV_COMPLETE |->
			res_data.frame_length == 16'h0 && res_data.channel_id == 16'h0)
		else $error("frame info set without completion");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.event_res <= EV_BAD_LLID)
		else $error("event code out of range");

endmodule

bind l2cap_fragment_reassembler_unit l2fr_checker u_l2fr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_data (res.data)
);

`default_nettype wire
